// ----- src/tfsd_pkg.sv -----
// Shared types, constants and word packing for the tracker frame sync decoder.
`default_nettype none

package tfsd_pkg;

   localparam int unsigned FRAME_DEPTH = 15;
   localparam int unsigned IDX_W       = $clog2(FRAME_DEPTH);

   localparam logic [IDX_W-1:0] FRAME_LEN_PLAIN = IDX_W'(14);
   localparam logic [IDX_W-1:0] FRAME_LEN_GROUP = IDX_W'(15);
   localparam int unsigned      PHASE_BIT       = 7;
   localparam logic [7:0]       DATA_MASK       = 8'h7f;
   localparam int unsigned      STATION_IDX     = 14;

   typedef logic [FRAME_DEPTH-1:0][7:0] frame_type;

   typedef struct packed {
      logic      done;
      frame_type frame;
   } frame_xfer_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic        [7:0]  station;
   } result_type;

   function automatic logic signed [15:0] pack_word(input logic [7:0] even_b,
                                                    input logic [7:0] odd_b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = even_b & DATA_MASK;
      hi = odd_b & DATA_MASK;
      return {hi[6:0], lo[6:0], 2'b00};
   endfunction

endpackage

`default_nettype wire

// ----- src/tfsd_frame_asm.sv -----
// Phasing byte hunt, byte counter and frame byte store.
`default_nettype none

module tfsd_frame_asm (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    xfer,
   input  wire logic [7:0]              rx_byte,
   input  wire logic                    group_mode,
   output tfsd_pkg::frame_xfer_type     frame_out
);

   logic [tfsd_pkg::IDX_W-1:0] held_ff;
   logic [tfsd_pkg::IDX_W-1:0] held_in;
   logic [tfsd_pkg::IDX_W-1:0] held_plus;
   logic [tfsd_pkg::IDX_W-1:0] frame_len;
   logic                       wr_en;
   logic                       done;
   logic [7:0]                 store_ff [tfsd_pkg::FRAME_DEPTH];

   assign held_plus = held_ff + tfsd_pkg::IDX_W'(1);
   assign frame_len = group_mode ? tfsd_pkg::FRAME_LEN_GROUP : tfsd_pkg::FRAME_LEN_PLAIN;

   always_comb begin
      held_in = held_ff;
      wr_en   = 1'b0;
      done    = 1'b0;
      if (xfer) begin
         if (held_ff == '0) begin
            if (rx_byte[tfsd_pkg::PHASE_BIT]) begin
               wr_en   = 1'b1;
               held_in = tfsd_pkg::IDX_W'(1);
            end
         end else begin
            wr_en = 1'b1;
            if (held_plus >= frame_len) begin
               done    = 1'b1;
               held_in = '0;
            end else begin
               held_in = held_plus;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[held_ff] <= rx_byte;
      end
   end

   // current byte is merged in at its slot so the last byte decodes in the same cycle
   always_comb begin
      frame_out.done = done;
      for (int i = 0; i < tfsd_pkg::FRAME_DEPTH; i++) begin
         frame_out.frame[i] = (held_ff == tfsd_pkg::IDX_W'(i)) ? rx_byte : store_ff[i];
      end
   end

endmodule

`default_nettype wire

// ----- src/tfsd_rsp_stage.sv -----
// Word decode and result register with valid/stall handshake.
`default_nettype none

module tfsd_rsp_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tfsd_pkg::frame_xfer_type frame_in,
   input  wire logic                    group_mode,
   input  wire logic                    rsp_stall,
   output logic                         rsp_valid,
   output tfsd_pkg::result_type         result
);

   logic                 valid_ff;
   logic                 valid_in;
   tfsd_pkg::result_type result_ff;
   tfsd_pkg::result_type result_in;

   always_comb begin
      result_in.pos_x   = tfsd_pkg::pack_word(frame_in.frame[0],  frame_in.frame[1]);
      result_in.pos_y   = tfsd_pkg::pack_word(frame_in.frame[2],  frame_in.frame[3]);
      result_in.pos_z   = tfsd_pkg::pack_word(frame_in.frame[4],  frame_in.frame[5]);
      result_in.quat_w  = tfsd_pkg::pack_word(frame_in.frame[6],  frame_in.frame[7]);
      result_in.quat_x  = tfsd_pkg::pack_word(frame_in.frame[8],  frame_in.frame[9]);
      result_in.quat_y  = tfsd_pkg::pack_word(frame_in.frame[10], frame_in.frame[11]);
      result_in.quat_z  = tfsd_pkg::pack_word(frame_in.frame[12], frame_in.frame[13]);
      result_in.station = group_mode ? frame_in.frame[tfsd_pkg::STATION_IDX] : 8'h00;
   end

   assign valid_in = frame_in.done | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_in.done) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

endmodule

`default_nettype wire

// ----- src/tracker_frame_sync_decoder.sv -----
// Top level: tracker frame sync decoder, serial bytes in, decoded frames out.
// rsp_valid rises in the cycle after a frame's last byte is transferred.
// One byte per cycle unless stalled; a frame is 14 bytes, or 15 in group mode.
// The input stalls only while a finished result is held and rsp_stall is high.
// Synchronous reset clears the byte count (hunting for a phasing byte),
// group_mode and the result valid; the frame store is not reset.
`default_nettype none

module tracker_frame_sync_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_pos_x,
   output logic signed [15:0]      rsp_pos_y,
   output logic signed [15:0]      rsp_pos_z,
   output logic signed [15:0]      rsp_quat_w,
   output logic signed [15:0]      rsp_quat_x,
   output logic signed [15:0]      rsp_quat_y,
   output logic signed [15:0]      rsp_quat_z,
   output logic [7:0]              rsp_station
);

   logic                     group_mode_ff;
   logic                     group_mode_in;
   logic                     req_xfer;
   tfsd_pkg::frame_xfer_type frame_xfer;
   tfsd_pkg::result_type     result;

   assign group_mode_in = csr_wr_en ? csr_wr_data : group_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_mode_ff <= 1'b0;
      end else begin
         group_mode_ff <= group_mode_in;
      end
   end

   assign req_stall = rsp_valid & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;

   tfsd_frame_asm u_frame_asm (
      .clock      (clock),
      .reset      (reset),
      .xfer       (req_xfer),
      .rx_byte    (req_rx_byte),
      .group_mode (group_mode_ff),
      .frame_out  (frame_xfer)
   );

   tfsd_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .frame_in   (frame_xfer),
      .group_mode (group_mode_ff),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .result     (result)
   );

   assign rsp_pos_x   = result.pos_x;
   assign rsp_pos_y   = result.pos_y;
   assign rsp_pos_z   = result.pos_z;
   assign rsp_quat_w  = result.quat_w;
   assign rsp_quat_x  = result.quat_x;
   assign rsp_quat_y  = result.quat_y;
   assign rsp_quat_z  = result.quat_z;
   assign rsp_station = result.station;

endmodule

`default_nettype wire

// ----- src/tfsd_checker.sv -----
// Port-level checks for the tracker frame sync decoder, bound to the top level.
`default_nettype none

module tfsd_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_stall,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic signed [15:0] rsp_pos_x,
   input  wire logic signed [15:0] rsp_pos_y,
   input  wire logic signed [15:0] rsp_pos_z,
   input  wire logic signed [15:0] rsp_quat_w,
   input  wire logic signed [15:0] rsp_quat_x,
   input  wire logic signed [15:0] rsp_quat_y,
   input  wire logic signed [15:0] rsp_quat_z,
   input  wire logic [7:0]         rsp_station
);

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid not cleared after reset");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_low_bits_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pos_x[1:0] == 2'b00 && rsp_pos_y[1:0] == 2'b00 &&
                     rsp_pos_z[1:0] == 2'b00 && rsp_quat_w[1:0] == 2'b00 &&
                     rsp_quat_x[1:0] == 2'b00 && rsp_quat_y[1:0] == 2'b00 &&
                     rsp_quat_z[1:0] == 2'b00))
      else $error("decoded word has nonzero low bits");

   a_held_result_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pos_x) &&
         $stable(rsp_pos_y) && $stable(rsp_pos_z) && $stable(rsp_quat_w) &&
         $stable(rsp_quat_x) && $stable(rsp_quat_y) && $stable(rsp_quat_z) &&
         $stable(rsp_station)))
      else $error("stalled result changed");

endmodule

bind tracker_frame_sync_decoder tfsd_checker u_tfsd_checker (.*);

`default_nettype wire
